// ===== sv/rmsedf_pkg.sv =====
// Shared types and constants of the rate-monotonic / EDF task selector.
package rmsedf_pkg;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;
  localparam int PERIOD_W   = 16;
  localparam int DEADLINE_W = 32;
  localparam int IDENT_W    = 8;
  localparam int CORE_W     = 4;
  localparam int SLICE_W    = 16;
  localparam int PRIO_W     = 20;

  localparam logic [PRIO_W-1:0] RMS_SCALE = 20'd1000000;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic POLICY_RMS = 1'b0;
  localparam logic POLICY_EDF = 1'b1;

  typedef struct packed {
    logic                  policy;
    logic                  qual;
    logic [PERIOD_W-1:0]   period;
    logic [DEADLINE_W-1:0] deadline;
    logic [IDENT_W-1:0]    ident;
    logic [CORE_W-1:0]     core;
    logic [SLICE_W-1:0]    slice;
    logic                  last;
  } task_entry_t;

endpackage

// ===== sv/rmsedf_front.sv =====
// Front end: policy register, descriptor classification and the task queue.
module rmsedf_front #(
  parameter int QUEUE_DEPTH = rmsedf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rmsedf_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                             in_tlast,
  output logic                             q_valid,
  input  logic                             q_ready,
  output rmsedf_pkg::task_entry_t          q_entry
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                    policy_r;
  logic [PTR_W-1:0]        wr_ptr_r;
  logic [PTR_W-1:0]        wr_ptr_nxt;
  logic [PTR_W-1:0]        rd_ptr_r;
  logic [PTR_W-1:0]        rd_ptr_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;
  rmsedf_pkg::task_entry_t mem_r [QUEUE_DEPTH];
  rmsedf_pkg::task_entry_t new_entry;
  logic                    push;
  logic                    pop;
  logic                    active;

  assign cfg_ready = 1'b1;

  assign active             = in_tdata[0];
  assign new_entry.policy   = policy_r;
  assign new_entry.period   = in_tdata[16:1];
  assign new_entry.deadline = in_tdata[48:17];
  assign new_entry.ident    = in_tdata[56:49];
  assign new_entry.core     = in_tdata[60:57];
  assign new_entry.slice    = in_tdata[76:61];
  assign new_entry.last     = in_tlast;
  assign new_entry.qual     = (policy_r == rmsedf_pkg::POLICY_RMS) ?
                              (active && (in_tdata[16:1] != '0)) : active;

  assign in_tready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_entry   = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= rmsedf_pkg::POLICY_RMS;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        policy_r <= cfg_data;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

// ===== sv/rmsedf_div.sv =====
// Bit-serial restoring divider that computes the rate-monotonic priority.
module rmsedf_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [rmsedf_pkg::PERIOD_W-1:0]    divisor,
  output logic                               busy,
  output logic                               done,
  output logic [rmsedf_pkg::PRIO_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(rmsedf_pkg::PRIO_W);
  localparam int DW    = rmsedf_pkg::PERIOD_W;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    div_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    rem_nxt;
  logic [rmsedf_pkg::PRIO_W-1:0] quo_r;
  logic [DW:0]      rem_shift;
  logic [DW:0]      diff;
  logic             ge;

  assign rem_shift = {rem_r, rmsedf_pkg::RMS_SCALE[cnt_r]};
  assign ge        = (rem_shift >= {1'b0, div_r});
  assign diff      = rem_shift - {1'b0, div_r};
  assign rem_nxt   = ge ? diff[DW-1:0] : rem_shift[DW-1:0];

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(rmsedf_pkg::PRIO_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[rmsedf_pkg::PRIO_W-2:0], ge};
    end
  end

endmodule

// ===== sv/rmsedf_back.sv =====
// Back end: compares each task against the running best and issues decisions.
module rmsedf_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  rmsedf_pkg::task_entry_t           q_entry,
  output logic                              div_start,
  output logic [rmsedf_pkg::PERIOD_W-1:0]   div_divisor,
  input  logic                              div_done,
  input  logic [rmsedf_pkg::PRIO_W-1:0]     div_quotient,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rmsedf_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0]                          state_r;
  logic [1:0]                          state_nxt;
  rmsedf_pkg::task_entry_t             cur_r;
  rmsedf_pkg::task_entry_t             cur_nxt;
  logic                                have_r;
  logic                                have_nxt;
  logic [rmsedf_pkg::PRIO_W-1:0]       prio_r;
  logic [rmsedf_pkg::PRIO_W-1:0]       prio_nxt;
  logic [rmsedf_pkg::DEADLINE_W-1:0]   dl_r;
  logic [rmsedf_pkg::DEADLINE_W-1:0]   dl_nxt;
  logic [rmsedf_pkg::IDENT_W-1:0]      ident_r;
  logic [rmsedf_pkg::IDENT_W-1:0]      ident_nxt;
  logic [rmsedf_pkg::CORE_W-1:0]       core_r;
  logic [rmsedf_pkg::CORE_W-1:0]       core_nxt;
  logic [rmsedf_pkg::SLICE_W-1:0]      slice_r;
  logic [rmsedf_pkg::SLICE_W-1:0]      slice_nxt;
  logic                                out_valid_r;
  logic                                out_valid_nxt;
  logic [rmsedf_pkg::OUT_DATA_W-1:0]   out_data_r;
  logic [rmsedf_pkg::OUT_DATA_W-1:0]   out_data_nxt;
  logic                                take_rms;
  logic                                take_edf;
  logic                                take;
  logic                                upd_have;
  logic [rmsedf_pkg::PRIO_W-1:0]       upd_prio;
  logic [rmsedf_pkg::DEADLINE_W-1:0]   upd_dl;
  logic [rmsedf_pkg::IDENT_W-1:0]      upd_ident;
  logic [rmsedf_pkg::CORE_W-1:0]       upd_core;
  logic [rmsedf_pkg::SLICE_W-1:0]      upd_slice;
  logic                                out_free;

  assign take_rms = (cur_r.policy == rmsedf_pkg::POLICY_RMS) && cur_r.qual &&
                    (!have_r || (div_quotient > prio_r));
  assign take_edf = (cur_r.policy == rmsedf_pkg::POLICY_EDF) && cur_r.qual &&
                    (cur_r.deadline < dl_r);
  assign take     = take_rms || take_edf;

  assign upd_have  = have_r || take;
  assign upd_prio  = take_rms ? div_quotient : prio_r;
  assign upd_dl    = take_edf ? cur_r.deadline : dl_r;
  assign upd_ident = take ? cur_r.ident : ident_r;
  assign upd_core  = take ? cur_r.core : core_r;
  assign upd_slice = take ? cur_r.slice : slice_r;

  assign out_free    = !out_valid_r || out_tready;
  assign div_divisor = q_entry.period;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    have_nxt      = have_r;
    prio_nxt      = prio_r;
    dl_nxt        = dl_r;
    ident_nxt     = ident_r;
    core_nxt      = core_r;
    slice_nxt     = slice_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    q_ready       = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cur_nxt = q_entry;
          if ((q_entry.policy == rmsedf_pkg::POLICY_RMS) && q_entry.qual) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!cur_r.last) begin
          have_nxt  = upd_have;
          prio_nxt  = upd_prio;
          dl_nxt    = upd_dl;
          ident_nxt = upd_ident;
          core_nxt  = upd_core;
          slice_nxt = upd_slice;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          if (upd_have) begin
            out_data_nxt = {3'b000, 1'b1, upd_slice, upd_core, upd_ident};
          end else begin
            out_data_nxt = '0;
          end
          have_nxt  = 1'b0;
          prio_nxt  = '0;
          dl_nxt    = '1;
          ident_nxt = '0;
          core_nxt  = '0;
          slice_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_r      <= 1'b0;
      prio_r      <= '0;
      dl_r        <= '1;
      ident_r     <= '0;
      core_r      <= '0;
      slice_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_r      <= have_nxt;
      prio_r      <= prio_nxt;
      dl_r        <= dl_nxt;
      ident_r     <= ident_nxt;
      core_r      <= core_nxt;
      slice_r     <= slice_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== sv/rms_edf_task_selector.sv =====
// Top level of the rate-monotonic / earliest-deadline-first task selector.
// Task descriptors arrive one transaction at a time on the in_ channel; the
// descriptor with in_tlast set closes a scan and produces one decision on the
// out_ channel. The cfg_ channel writes the policy bit (0 rate monotonic,
// 1 earliest deadline first) and is always ready; it applies to descriptors
// accepted after the write. Accepted descriptors wait in a short queue
// in front of the comparison unit. A descriptor that needs no priority
// division goes from IDLE straight to EVAL in the back end; an active
// rate-monotonic descriptor with a nonzero period waits in DIV for the
// bit-serial divider that forms 1000000 / period one quotient bit per cycle.
// out_tvalid rises in the cycle after EVAL closes the scan of a decision.
// If the receiver holds out_tready low, the decision stays in the output
// register, the back end stops at the next scan end, the queue fills and
// in_tready drops. Reset clears the queue, the running best and the output,
// and selects rate-monotonic policy.
module rms_edf_task_selector #(
  parameter int QUEUE_DEPTH = rmsedf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // task_active, task_period, task_deadline, task_ident, task_core,
  // task_exec_time, zero padding
  input  logic [rmsedf_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // chosen_ident, chosen_core, chosen_slice, found, zero padding
  output logic [rmsedf_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic                                  q_valid;
  logic                                  q_ready;
  rmsedf_pkg::task_entry_t               q_entry;
  logic                                  div_start;
  logic [rmsedf_pkg::PERIOD_W-1:0]       div_divisor;
  logic                                  div_busy;
  logic                                  div_done;
  logic [rmsedf_pkg::PRIO_W-1:0]         div_quotient;

  rmsedf_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry)
  );

  rmsedf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  rmsedf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_entry      (q_entry),
    .div_start    (div_start),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (div_divisor != '0))
    else $error("divider started with zero period");

  a_empty_decision: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[28]) |-> (out_tdata[27:0] == '0))
    else $error("decision without winner carries nonzero fields");

  a_out_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule

// ===== bench/rms_edf_task_selector_tb.sv =====
// Self-checking testbench for the rate-monotonic / earliest-deadline-first task selector.
module rms_edf_task_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int PHASE_ITEMS   = 250;
  localparam int RANDOM_PHASES = 8;

  typedef struct {
    bit                              active;
    bit [rmsedf_pkg::PERIOD_W-1:0]   period;
    bit [rmsedf_pkg::DEADLINE_W-1:0] deadline;
    bit [rmsedf_pkg::IDENT_W-1:0]    ident;
    bit [rmsedf_pkg::CORE_W-1:0]     core;
    bit [rmsedf_pkg::SLICE_W-1:0]    exec_time;
    bit                              last;
  } descriptor_t;

  typedef struct {
    bit [rmsedf_pkg::IDENT_W-1:0] ident;
    bit [rmsedf_pkg::CORE_W-1:0]  core;
    bit [rmsedf_pkg::SLICE_W-1:0] slice;
    bit                           found;
  } decision_t;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic                              cfg_data = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [rmsedf_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                              in_tlast = 1'b0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [rmsedf_pkg::OUT_DATA_W-1:0] out_tdata;

  logic                              sel_mode;
  bit                                have_best;
  bit [rmsedf_pkg::PRIO_W-1:0]       best_prio;
  bit [rmsedf_pkg::DEADLINE_W-1:0]   best_deadline;
  bit [rmsedf_pkg::IDENT_W-1:0]      best_ident;
  bit [rmsedf_pkg::CORE_W-1:0]       best_core;
  bit [rmsedf_pkg::SLICE_W-1:0]      best_slice;

  decision_t             pending_decisions[$];
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  int                    hold_request = 0;
  bit                    send_idle = 1'b1;
  bit                    recv_idle = 1'b1;

  rms_edf_task_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [rmsedf_pkg::IN_DATA_W-1:0] pack_descriptor(input descriptor_t d);
    return {3'b000, d.exec_time, d.core, d.ident, d.deadline, d.period, d.active};
  endfunction

  function automatic descriptor_t make_desc(input bit active, input int unsigned period,
                                            input int unsigned deadline, input int unsigned ident,
                                            input int unsigned core, input int unsigned exec_time,
                                            input bit last);
    descriptor_t d;
    d.active    = active;
    d.period    = period[rmsedf_pkg::PERIOD_W-1:0];
    d.deadline  = deadline;
    d.ident     = ident[rmsedf_pkg::IDENT_W-1:0];
    d.core      = core[rmsedf_pkg::CORE_W-1:0];
    d.exec_time = exec_time[rmsedf_pkg::SLICE_W-1:0];
    d.last      = last;
    return d;
  endfunction

  function automatic void clear_best();
    have_best     = 1'b0;
    best_prio     = '0;
    best_deadline = '1;
    best_ident    = '0;
    best_core     = '0;
    best_slice    = '0;
  endfunction

  // Folds one descriptor into the running best and returns 1 when it closes a scan.
  function automatic bit advance_scan(input descriptor_t d, output decision_t dec);
    bit                          take;
    bit [rmsedf_pkg::PRIO_W-1:0] prio;
    take = 1'b0;
    dec  = '{default: '0};
    if (sel_mode == rmsedf_pkg::POLICY_RMS) begin
      if (d.active && d.period != 0) begin
        prio = rmsedf_pkg::PRIO_W'(int'(rmsedf_pkg::RMS_SCALE) / int'(d.period));
        if (!have_best || prio > best_prio) begin
          best_prio = prio;
          take      = 1'b1;
        end
      end
    end else begin
      if (d.active && d.deadline < best_deadline) begin
        best_deadline = d.deadline;
        take          = 1'b1;
      end
    end
    if (take) begin
      have_best  = 1'b1;
      best_ident = d.ident;
      best_core  = d.core;
      best_slice = d.exec_time;
    end
    if (!d.last) return 1'b0;
    if (have_best) begin
      dec.ident = best_ident;
      dec.core  = best_core;
      dec.slice = best_slice;
      dec.found = 1'b1;
    end
    clear_best();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", field, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic check_decision(input logic [rmsedf_pkg::OUT_DATA_W-1:0] word);
    decision_t want;
    if (pending_decisions.size() == 0) begin
      report_mismatch("unexpected decision", word, '0);
      return;
    end
    want = pending_decisions.pop_front();
    if (word[7:0] !== want.ident)
      report_mismatch("chosen_ident", 32'(word[7:0]), 32'(want.ident));
    if (word[11:8] !== want.core)
      report_mismatch("chosen_core", 32'(word[11:8]), 32'(want.core));
    if (word[27:12] !== want.slice)
      report_mismatch("chosen_slice", 32'(word[27:12]), 32'(want.slice));
    if (word[28] !== want.found)
      report_mismatch("found", 32'(word[28]), 32'(want.found));
    if (word[31:29] !== 3'b000) report_mismatch("padding", 32'(word[31:29]), '0);
  endtask

  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_decision(out_tdata);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        stall_left = pick_gap(recv_idle);
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  task automatic send_descriptor(input descriptor_t d);
    int        gap;
    decision_t dec;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_descriptor(d);
    in_tlast  <= d.last;
    do @(posedge clk); while (!in_tready);
    if (advance_scan(d, dec)) pending_decisions.push_back(dec);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_decisions.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(input logic mode);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sel_mode = mode;
  endtask

  function automatic descriptor_t random_descriptor();
    descriptor_t d;
    int          r;
    d.active = ($urandom_range(0, 99) < 85);
    r = $urandom_range(0, 9);
    if (r == 0) d.period = '0;
    else if (r == 1) d.period = 16'd1;
    else if (r == 2) d.period = '1;
    else if (r < 6) d.period = rmsedf_pkg::PERIOD_W'($urandom_range(1, 255));
    else d.period = rmsedf_pkg::PERIOD_W'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) d.deadline = '1;
    else if (r == 1) d.deadline = '0;
    else if (r < 4) d.deadline = $urandom_range(0, 15);
    else d.deadline = $urandom;
    d.ident     = rmsedf_pkg::IDENT_W'($urandom);
    d.core      = rmsedf_pkg::CORE_W'($urandom);
    d.exec_time = rmsedf_pkg::SLICE_W'($urandom);
    d.last      = 1'b0;
    return d;
  endfunction

  task automatic send_random_scan(input int len);
    descriptor_t d;
    for (int i = 0; i < len; i++) begin
      d      = random_descriptor();
      d.last = (i == len - 1);
      send_descriptor(d);
    end
  endtask

  task automatic test_rms_selection();
    write_policy(rmsedf_pkg::POLICY_RMS);
    send_descriptor(make_desc(1'b1, 65535, 32'h0000_0010, 'h01, 1, 'h0001, 1'b0));
    send_descriptor(make_desc(1'b1, 65000, 32'h0000_0020, 'h02, 2, 'h0002, 1'b0));
    send_descriptor(make_desc(1'b0, 1, 32'h0000_0001, 'h03, 3, 'h0003, 1'b0));
    send_descriptor(make_desc(1'b1, 0, 32'h0000_0002, 'h04, 4, 'h0004, 1'b0));
    send_descriptor(make_desc(1'b1, 1000, 32'hFFFF_FFFF, 'h05, 5, 'h0005, 1'b0));
    send_descriptor(make_desc(1'b0, 1, 32'h0000_0000, 'h06, 6, 'h0006, 1'b1));
    send_descriptor(make_desc(1'b1, 1, 32'h0000_0000, 'hFF, 15, 'hFFFF, 1'b1));
    send_descriptor(make_desc(1'b0, 1, 32'h0000_0005, 'h07, 7, 'h0007, 1'b1));
    send_descriptor(make_desc(1'b1, 0, 32'h0000_0005, 'h08, 8, 'h0008, 1'b0));
    send_descriptor(make_desc(1'b1, 0, 32'h0000_0006, 'h09, 9, 'h0009, 1'b1));
    send_descriptor(make_desc(1'b1, 3, 32'h0000_0007, 'h0A, 10, 'h000A, 1'b0));
    send_descriptor(make_desc(1'b1, 2, 32'h0000_0008, 'h0B, 11, 'h000B, 1'b1));
  endtask

  task automatic test_edf_selection();
    write_policy(rmsedf_pkg::POLICY_EDF);
    send_descriptor(make_desc(1'b1, 0, 32'hFFFF_FFFF, 'h21, 1, 'h0100, 1'b0));
    send_descriptor(make_desc(1'b1, 5, 32'd100, 'h22, 2, 'h0200, 1'b0));
    send_descriptor(make_desc(1'b1, 6, 32'd100, 'h23, 3, 'h0300, 1'b0));
    send_descriptor(make_desc(1'b0, 7, 32'd5, 'h24, 4, 'h0400, 1'b0));
    send_descriptor(make_desc(1'b1, 8, 32'd99, 'h25, 5, 'h0500, 1'b1));
    send_descriptor(make_desc(1'b1, 1, 32'hFFFF_FFFF, 'h26, 6, 'h0600, 1'b1));
    send_descriptor(make_desc(1'b1, 0, 32'h0000_0000, 'hFF, 15, 'hFFFF, 1'b1));
  endtask

  task automatic test_policy_switch_midscan();
    write_policy(rmsedf_pkg::POLICY_RMS);
    send_descriptor(make_desc(1'b1, 10, 32'd500, 'h41, 1, 'h1111, 1'b0));
    write_policy(rmsedf_pkg::POLICY_EDF);
    send_descriptor(make_desc(1'b1, 1, 32'd1000, 'h42, 2, 'h2222, 1'b0));
    send_descriptor(make_desc(1'b1, 2, 32'd2000, 'h43, 3, 'h3333, 1'b1));
    send_descriptor(make_desc(1'b1, 9, 32'd50, 'h44, 4, 'h4444, 1'b0));
    write_policy(rmsedf_pkg::POLICY_RMS);
    send_descriptor(make_desc(1'b1, 50, 32'd60, 'h45, 5, 'h5555, 1'b0));
    send_descriptor(make_desc(1'b1, 100, 32'd10, 'h46, 6, 'h6666, 1'b1));
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_idle = 1'b0;
    hold_request = 400;
    for (int i = 0; i < 8; i++) send_random_scan($urandom_range(2, 4));
    wait_idle();
    send_idle = 1'b1;
  endtask

  task automatic test_random_scans();
    int          sent;
    int          len;
    descriptor_t d;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_policy((p % 2 == 0) ? rmsedf_pkg::POLICY_RMS : rmsedf_pkg::POLICY_EDF);
      send_idle = (p % 4 != 1);
      recv_idle = (p % 4 != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          d      = random_descriptor();
          d.last = 1'($urandom_range(0, 1));
          send_descriptor(d);
          sent++;
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
          send_random_scan(len);
          sent += len;
        end
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    sel_mode = rmsedf_pkg::POLICY_RMS;
    clear_best();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rms_selection();
    test_edf_selection();
    test_policy_switch_midscan();
    test_backpressure();
    test_random_scans();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
